[hdl/assert_macros.svh]
// Assertion macros shared by the vital-sign alarm RTL.
// Every macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define VSAD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition that must never hold outside reset.
`define VSAD_ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

[hdl/vsad_pkg.sv]
// Shared types and constants for the vital-sign threshold alarm.
// No dependencies; imported by every module of the block.
`default_nettype none

package vsad_pkg;

	localparam int S_TDATA_W   = 64;
	localparam int S_TUSER_W   = 2;
	localparam int M_TDATA_W   = 8;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		GRADE_VERY_LOW  = 3'd0,
		GRADE_LOW       = 3'd1,
		GRADE_NORMAL    = 3'd2,
		GRADE_HIGH      = 3'd3,
		GRADE_VERY_HIGH = 3'd4,
		GRADE_INVALID   = 3'd5
	} grade_t;

	typedef enum logic [1:0] {
		ACT_RESTING = 2'd0,
		ACT_RUNNING = 2'd1,
		ACT_OTHER   = 2'd2
	} activity_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_HR_VERY_LOW_MAX    = 3'd0,
		REG_HR_LOW_MAX         = 3'd1,
		REG_HR_NORMAL_MAX      = 3'd2,
		REG_HR_HIGH_MAX        = 3'd3,
		REG_SAT_VERY_LOW_MAX   = 3'd4,
		REG_SAT_LOW_MAX        = 3'd5,
		REG_SAT_NORMAL_MAX     = 3'd6,
		REG_RESEND_INTERVAL_MS = 3'd7
	} reg_idx_t;

	localparam logic [7:0]  HR_VERY_LOW_RESET    = 8'd39;
	localparam logic [7:0]  HR_LOW_RESET         = 8'd59;
	localparam logic [7:0]  HR_NORMAL_RESET      = 8'd100;
	localparam logic [7:0]  HR_HIGH_RESET        = 8'd120;
	localparam logic [6:0]  SPO2_VERY_LOW_RESET  = 7'd88;
	localparam logic [6:0]  SPO2_LOW_RESET       = 7'd94;
	localparam logic [6:0]  SPO2_NORMAL_RESET    = 7'd100;
	localparam logic [31:0] RESEND_INTERVAL_RESET = 32'd60000;

	typedef struct packed {
		logic [7:0]  hr_very_low_max;
		logic [7:0]  hr_low_max;
		logic [7:0]  hr_normal_max;
		logic [7:0]  hr_high_max;
		logic [6:0]  sat_very_low_max;
		logic [6:0]  sat_low_max;
		logic [6:0]  sat_normal_max;
		logic [31:0] resend_interval_ms;
	} cfg_t;

	// Classified sample handed from the front end to the alarm back end
	typedef struct packed {
		logic        sample_valid;
		grade_t      hr_grade;
		grade_t      spo2_grade;
		logic        hr_cond;
		logic        spo2_cond;
		logic [31:0] now_ms;
	} cls_t;

	typedef struct packed {
		logic   sample_valid;
		grade_t hr_grade;
		grade_t spo2_grade;
		logic   hr_alert_send;
		logic   spo2_alert_send;
	} result_t;

	typedef struct packed {
		logic [7:0]  hold_count;
		logic        alarm_on;
		logic [31:0] last_send_ms;
	} meas_state_t;

endpackage

`default_nettype wire

[hdl/vsad_front.sv]
// Front end: accepts samples, rejects flagged or zero readings and grades both measures.
// Depends on vsad_pkg; feeds vsad_queue.
`default_nettype none

module vsad_front (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire vsad_pkg::cfg_t         cfg,
	input  wire                         s_tvalid,
	output logic                        s_tready,
	input  wire [vsad_pkg::S_TDATA_W-1:0] s_tdata,
	input  wire [vsad_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                        cls_valid,
	input  wire                         cls_ready,
	output vsad_pkg::cls_t              cls_data
);
	import vsad_pkg::*;

	logic [11:0] pulse_rate;
	logic [10:0] oxygen_sat;
	logic [1:0]  activity;
	logic [31:0] now_ms;
	logic        hr_nan;
	logic        sat_nan;
	logic        accepted;
	grade_t      hr_grade;
	grade_t      spo2_grade;
	cls_t        cls_c;
	logic        vld_s1;
	cls_t        cls_s1;

	assign pulse_rate = s_tdata[11:0];
	assign oxygen_sat = s_tdata[22:12];
	assign activity   = s_tdata[24:23];
	assign now_ms     = s_tdata[56:25];
	assign hr_nan     = s_tuser[0];
	assign sat_nan    = s_tuser[1];

	assign accepted = !hr_nan && !sat_nan && (pulse_rate != 12'd0) && (oxygen_sat != 11'd0);

	// Thresholds are tested in order; the first that holds wins
	always_comb begin
		if (activity != ACT_RESTING && activity != ACT_RUNNING) begin
			hr_grade = GRADE_INVALID;
		end else if (pulse_rate <= {cfg.hr_very_low_max, 4'd0}) begin
			hr_grade = GRADE_VERY_LOW;
		end else if (pulse_rate <= {cfg.hr_low_max, 4'd0}) begin
			hr_grade = GRADE_LOW;
		end else if (pulse_rate <= {cfg.hr_normal_max, 4'd0}) begin
			hr_grade = GRADE_NORMAL;
		end else if (pulse_rate <= {cfg.hr_high_max, 4'd0}) begin
			hr_grade = GRADE_HIGH;
		end else begin
			hr_grade = GRADE_VERY_HIGH;
		end
	end

	always_comb begin
		if (oxygen_sat <= {cfg.sat_very_low_max, 4'd0}) begin
			spo2_grade = GRADE_VERY_LOW;
		end else if (oxygen_sat <= {cfg.sat_low_max, 4'd0}) begin
			spo2_grade = GRADE_LOW;
		end else if (oxygen_sat <= {cfg.sat_normal_max, 4'd0}) begin
			spo2_grade = GRADE_NORMAL;
		end else begin
			spo2_grade = GRADE_INVALID;
		end
	end

	always_comb begin
		cls_c.now_ms = now_ms;
		if (accepted) begin
			cls_c.sample_valid = 1'b1;
			cls_c.hr_grade     = hr_grade;
			cls_c.spo2_grade   = spo2_grade;
			cls_c.hr_cond      = hr_grade inside {GRADE_VERY_LOW, GRADE_LOW,
				GRADE_HIGH, GRADE_VERY_HIGH};
			cls_c.spo2_cond    = spo2_grade inside {GRADE_VERY_LOW, GRADE_LOW};
		end else begin
			cls_c.sample_valid = 1'b0;
			cls_c.hr_grade     = GRADE_INVALID;
			cls_c.spo2_grade   = GRADE_INVALID;
			cls_c.hr_cond      = 1'b0;
			cls_c.spo2_cond    = 1'b0;
		end
	end

	// Hold the graded sample until the queue takes it
	assign s_tready = !vld_s1 || cls_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cls_s1 <= cls_c;
		end
	end

	assign cls_valid = vld_s1;
	assign cls_data  = cls_s1;

endmodule

`default_nettype wire

[hdl/vsad_queue.sv]
// Short FIFO of classified samples between the front end and the alarm back end.
// Depends on vsad_pkg for the entry type.
`default_nettype none

module vsad_queue #(
	parameter int DEPTH = 2
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push_valid,
	output logic                 push_ready,
	input  wire vsad_pkg::cls_t  push_data,
	output logic                 pop_valid,
	input  wire                  pop_ready,
	output vsad_pkg::cls_t       pop_data
);
	import vsad_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	cls_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

[hdl/vsad_back.sv]
// Back end: per-measure debounce and resend timing, plus the result output register.
// Depends on vsad_pkg; takes entries from vsad_queue.
`default_nettype none

module vsad_back #(
	parameter int DEBOUNCE_COUNT = 3
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire vsad_pkg::cfg_t          cfg,
	input  wire                          cls_valid,
	output logic                         cls_ready,
	input  wire vsad_pkg::cls_t          cls_data,
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [vsad_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                         m_tuser
);
	import vsad_pkg::*;

	localparam logic [7:0] HOLD_LIMIT = 8'(DEBOUNCE_COUNT);

	typedef struct packed {
		meas_state_t st;
		logic        send;
	} deb_t;

	meas_state_t hr_st_q;
	meas_state_t spo2_st_q;
	deb_t        hr_deb;
	deb_t        spo2_deb;
	logic        take;
	logic        m_tvalid_q;
	result_t     res_q;

	function automatic deb_t debounce(meas_state_t st, logic cond, logic [31:0] now,
		logic [31:0] interval);
		deb_t        r;
		logic [7:0]  cnt;
		logic [31:0] elapsed;
		cnt     = (st.hold_count == 8'hFF) ? st.hold_count : st.hold_count + 8'd1;
		elapsed = now - st.last_send_ms;
		r.st    = st;
		r.send  = 1'b0;
		if (!cond) begin
			r.st.hold_count = 8'd0;
			r.st.alarm_on   = 1'b0;
		end else begin
			r.st.hold_count = cnt;
			if (cnt >= HOLD_LIMIT && !st.alarm_on) begin
				r.st.alarm_on     = 1'b1;
				r.st.last_send_ms = now;
				r.send            = 1'b1;
			end else if (st.alarm_on && elapsed >= interval) begin
				r.st.last_send_ms = now;
				r.send            = 1'b1;
			end
		end
		return r;
	endfunction

	assign hr_deb   = debounce(hr_st_q, cls_data.hr_cond, cls_data.now_ms,
		cfg.resend_interval_ms);
	assign spo2_deb = debounce(spo2_st_q, cls_data.spo2_cond, cls_data.now_ms,
		cfg.resend_interval_ms);

	// Advance whenever the output register is empty or being drained
	assign cls_ready = !m_tvalid_q || m_tready;
	assign take      = cls_valid && cls_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			hr_st_q    <= '0;
			spo2_st_q  <= '0;
		end else begin
			if (cls_ready) begin
				m_tvalid_q <= cls_valid;
			end
			// Rejected samples leave the alarm state untouched
			if (take && cls_data.sample_valid) begin
				hr_st_q   <= hr_deb.st;
				spo2_st_q <= spo2_deb.st;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q.sample_valid    <= cls_data.sample_valid;
			res_q.hr_grade        <= cls_data.hr_grade;
			res_q.spo2_grade      <= cls_data.spo2_grade;
			res_q.hr_alert_send   <= cls_data.sample_valid && hr_deb.send;
			res_q.spo2_alert_send <= cls_data.sample_valid && spo2_deb.send;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = res_q.sample_valid;
	assign m_tdata  = {res_q.spo2_alert_send, res_q.hr_alert_send,
		res_q.spo2_grade, res_q.hr_grade};

endmodule

`default_nettype wire

[hdl/vital_sign_alarm_debounce.sv]
// Vital-sign threshold alarm with debounce and resend: top level and register file.
// Depends on vsad_pkg, vsad_front, vsad_queue, vsad_back and assert_macros.svh.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  s_*     | in        | s_tvalid/s_tready  | samples: tdata 64 bits, tuser 2 flag bits
//  m_*     | out       | m_tvalid/m_tready  | results: tdata 8 bits, tuser sample_valid
//  cfg_*   | in        | cfg_valid/cfg_ready| register index 3 bits, data 32 bits
//
// One sample per cycle sustained while m_tready stays high; a result reaches m_* through
// the front grading register, one queue slot and the back output register.
// The debounce state updates in the back end as each result is registered, so
// consecutive samples see each other's effect with no bubble.
// arst_n clears the pipeline, the queue and the alarm state and loads the threshold
// reset values. A stall on m_* fills the output register, then the queue, then the
// front register before s_tready drops. cfg_ready is always high.
`default_nettype none
`include "assert_macros.svh"

module vital_sign_alarm_debounce #(
	parameter int DEBOUNCE_COUNT = 3
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	// pulse_rate[11:0], oxygen_sat[22:12], activity[24:23], now_ms[56:25], zeros above
	input  wire [vsad_pkg::S_TDATA_W-1:0]    s_tdata,
	// pulse_rate_nan[0], oxygen_sat_nan[1]
	input  wire [vsad_pkg::S_TUSER_W-1:0]    s_tuser,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// hr_grade[2:0], spo2_grade[5:3], hr_alert_send[6], spo2_alert_send[7]
	output logic [vsad_pkg::M_TDATA_W-1:0]   m_tdata,
	// sample_valid[0]
	output logic                             m_tuser,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire [vsad_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire [vsad_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import vsad_pkg::*;

	cfg_t   cfg_q;
	logic   f2q_valid;
	logic   f2q_ready;
	cls_t   f2q_data;
	logic   q2b_valid;
	logic   q2b_ready;
	cls_t   q2b_data;
	grade_t out_hr_grade;
	grade_t out_spo2_grade;
	logic   out_hr_send;
	logic   out_spo2_send;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hr_very_low_max    <= HR_VERY_LOW_RESET;
			cfg_q.hr_low_max         <= HR_LOW_RESET;
			cfg_q.hr_normal_max      <= HR_NORMAL_RESET;
			cfg_q.hr_high_max        <= HR_HIGH_RESET;
			cfg_q.sat_very_low_max   <= SPO2_VERY_LOW_RESET;
			cfg_q.sat_low_max        <= SPO2_LOW_RESET;
			cfg_q.sat_normal_max     <= SPO2_NORMAL_RESET;
			cfg_q.resend_interval_ms <= RESEND_INTERVAL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_HR_VERY_LOW_MAX:    cfg_q.hr_very_low_max    <= cfg_data[7:0];
				REG_HR_LOW_MAX:         cfg_q.hr_low_max         <= cfg_data[7:0];
				REG_HR_NORMAL_MAX:      cfg_q.hr_normal_max      <= cfg_data[7:0];
				REG_HR_HIGH_MAX:        cfg_q.hr_high_max        <= cfg_data[7:0];
				REG_SAT_VERY_LOW_MAX:   cfg_q.sat_very_low_max   <= cfg_data[6:0];
				REG_SAT_LOW_MAX:        cfg_q.sat_low_max        <= cfg_data[6:0];
				REG_SAT_NORMAL_MAX:     cfg_q.sat_normal_max     <= cfg_data[6:0];
				REG_RESEND_INTERVAL_MS: cfg_q.resend_interval_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	vsad_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cls_valid (f2q_valid),
		.cls_ready (f2q_ready),
		.cls_data  (f2q_data)
	);

	vsad_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f2q_valid),
		.push_ready (f2q_ready),
		.push_data  (f2q_data),
		.pop_valid  (q2b_valid),
		.pop_ready  (q2b_ready),
		.pop_data   (q2b_data)
	);

	vsad_back #(
		.DEBOUNCE_COUNT (DEBOUNCE_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cls_valid (q2b_valid),
		.cls_ready (q2b_ready),
		.cls_data  (q2b_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	assign out_hr_grade   = grade_t'(m_tdata[2:0]);
	assign out_spo2_grade = grade_t'(m_tdata[5:3]);
	assign out_hr_send    = m_tdata[6];
	assign out_spo2_send  = m_tdata[7];

	`VSAD_ASSERT_IMPL(a_reject_quiet, m_tvalid && !m_tuser,
		out_hr_grade == GRADE_INVALID && out_spo2_grade == GRADE_INVALID &&
		!out_hr_send && !out_spo2_send, "rejected sample carries grades or sends")
	`VSAD_ASSERT_IMPL(a_hr_send_cond, m_tvalid && out_hr_send,
		out_hr_grade != GRADE_NORMAL && out_hr_grade != GRADE_INVALID,
		"heart-rate alert sent without a raised condition")
	`VSAD_ASSERT_IMPL(a_spo2_send_cond, m_tvalid && out_spo2_send,
		out_spo2_grade == GRADE_VERY_LOW || out_spo2_grade == GRADE_LOW,
		"SpO2 alert sent without a raised condition")
	`VSAD_ASSERT_NEVER(a_spo2_grade_range, m_tvalid && (out_spo2_grade == GRADE_HIGH ||
		out_spo2_grade == GRADE_VERY_HIGH), "SpO2 graded above normal")

endmodule

`default_nettype wire

[tb/vital_sign_alarm_debounce_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the vital-sign threshold alarm: a directed table, then random
// sample runs under several threshold and resend settings, checked by an in-bench predictor.
// Depends on vsad_pkg and the vital_sign_alarm_debounce RTL.

module vital_sign_alarm_debounce_tb;
	import vsad_pkg::*;

	localparam int ALARM_HOLD = 3;
	localparam int IDLE_PCT = 30;
	localparam int PHASE_ITEMS = 280;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DIRECTED_COUNT = 22;
	localparam logic [1:0] ACT_UNDEFINED = 2'd3;

	typedef struct packed {
		logic [11:0] pulse_rate;
		logic        pulse_rate_nan;
		logic [10:0] oxygen_sat;
		logic        oxygen_sat_nan;
		logic [1:0]  activity;
		logic [31:0] now_ms;
	} vitals_t;

	typedef struct packed {
		vitals_t smp;
		logic    typed;
		result_t want;
	} vitals_row_t;

	localparam result_t REJECTED = '{sample_valid: 1'b0, hr_grade: GRADE_INVALID,
		spo2_grade: GRADE_INVALID, hr_alert_send: 1'b0, spo2_alert_send: 1'b0};
	localparam result_t FIRST_VERY_HIGH = '{sample_valid: 1'b1, hr_grade: GRADE_VERY_HIGH,
		spo2_grade: GRADE_INVALID, hr_alert_send: 1'b0, spo2_alert_send: 1'b0};
	localparam result_t BOTH_VERY_LOW = '{sample_valid: 1'b1, hr_grade: GRADE_VERY_LOW,
		spo2_grade: GRADE_VERY_LOW, hr_alert_send: 1'b0, spo2_alert_send: 1'b0};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [S_TUSER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predictor copy of the registers and the per-measure alarm state
	logic [7:0] hr_thr [4];
	logic [6:0] sat_thr [3];
	logic [31:0] resend_ms;
	meas_state_t hr_track;
	meas_state_t sat_track;
	logic [31:0] clock_ms = '0;

	result_t awaited_results [$];
	int mismatches = 0;
	int cycle_count = 0;
	logic quiet = 1'b0;

	// threshold boundaries, both measures, rejections, wrap of the timestamp
	vitals_row_t directed_rows [DIRECTED_COUNT] = '{
		'{'{12'd0,    1'b0, 11'd1552, 1'b0, ACT_RESTING,   32'd0},          1'b1, REJECTED},
		'{'{12'd1200, 1'b0, 11'd0,    1'b0, ACT_RESTING,   32'd10},         1'b1, REJECTED},
		'{'{12'd1200, 1'b1, 11'd1552, 1'b0, ACT_RUNNING,   32'd20},         1'b1, REJECTED},
		'{'{12'd1200, 1'b0, 11'd1552, 1'b1, ACT_RUNNING,   32'd30},         1'b1, REJECTED},
		'{'{12'd4095, 1'b0, 11'd2047, 1'b0, ACT_RUNNING,   32'd100},        1'b1, FIRST_VERY_HIGH},
		'{'{12'd1,    1'b0, 11'd1,    1'b0, ACT_RESTING,   32'd200},        1'b1, BOTH_VERY_LOW},
		'{'{12'd624,  1'b0, 11'd1408, 1'b0, ACT_RESTING,   32'd300},        1'b0, REJECTED},
		'{'{12'd625,  1'b0, 11'd1409, 1'b0, ACT_RUNNING,   32'd400},        1'b0, REJECTED},
		'{'{12'd944,  1'b0, 11'd1504, 1'b0, ACT_RESTING,   32'd60400},      1'b0, REJECTED},
		'{'{12'd945,  1'b0, 11'd1505, 1'b0, ACT_RESTING,   32'd60500},      1'b0, REJECTED},
		'{'{12'd1600, 1'b0, 11'd1600, 1'b0, ACT_RUNNING,   32'd60600},      1'b0, REJECTED},
		'{'{12'd1601, 1'b0, 11'd1601, 1'b0, ACT_RESTING,   32'd60700},      1'b0, REJECTED},
		'{'{12'd1920, 1'b0, 11'd2047, 1'b0, ACT_OTHER,     32'd60800},      1'b0, REJECTED},
		'{'{12'd1921, 1'b0, 11'd2047, 1'b0, ACT_UNDEFINED, 32'd60900},      1'b0, REJECTED},
		'{'{12'd1921, 1'b0, 11'd16,   1'b0, ACT_RESTING,   32'hFFFF_FF00},  1'b0, REJECTED},
		'{'{12'd1921, 1'b0, 11'd16,   1'b0, ACT_RUNNING,   32'hFFFF_FFFF},  1'b0, REJECTED},
		'{'{12'd1921, 1'b0, 11'd16,   1'b0, ACT_RESTING,   32'd0},          1'b0, REJECTED},
		'{'{12'd1921, 1'b0, 11'd16,   1'b0, ACT_RESTING,   32'd59999},      1'b0, REJECTED},
		'{'{12'd1921, 1'b0, 11'd16,   1'b0, ACT_RESTING,   32'd60000},      1'b0, REJECTED},
		'{'{12'd1921, 1'b1, 11'd16,   1'b0, ACT_RESTING,   32'd60001},      1'b1, REJECTED},
		'{'{12'd1921, 1'b0, 11'd16,   1'b0, ACT_RESTING,   32'hFFFF_0000},  1'b0, REJECTED},
		'{'{12'd1921, 1'b0, 11'd16,   1'b0, ACT_OTHER,     32'hFFFF_0001},  1'b0, REJECTED}
	};

	vital_sign_alarm_debounce #(
		.DEBOUNCE_COUNT(ALARM_HOLD)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	function automatic grade_t grade_heart(logic [11:0] hr, logic [1:0] act);
		if (act != ACT_RESTING && act != ACT_RUNNING)
			return GRADE_INVALID;
		if (hr <= {hr_thr[0], 4'h0}) return GRADE_VERY_LOW;
		if (hr <= {hr_thr[1], 4'h0}) return GRADE_LOW;
		if (hr <= {hr_thr[2], 4'h0}) return GRADE_NORMAL;
		if (hr <= {hr_thr[3], 4'h0}) return GRADE_HIGH;
		return GRADE_VERY_HIGH;
	endfunction

	function automatic grade_t grade_oxygen(logic [10:0] sat);
		if (sat <= {sat_thr[0], 4'h0}) return GRADE_VERY_LOW;
		if (sat <= {sat_thr[1], 4'h0}) return GRADE_LOW;
		if (sat <= {sat_thr[2], 4'h0}) return GRADE_NORMAL;
		return GRADE_INVALID;
	endfunction

	// count up while the condition holds; send once debounced, then once per interval
	function automatic logic advance_alarm(inout meas_state_t st, input logic cond,
		input logic [31:0] now);
		if (!cond) begin
			st.hold_count = 8'd0;
			st.alarm_on = 1'b0;
			return 1'b0;
		end
		if (st.hold_count != 8'hFF)
			st.hold_count = st.hold_count + 8'd1;
		if (st.hold_count >= ALARM_HOLD && !st.alarm_on) begin
			st.alarm_on = 1'b1;
			st.last_send_ms = now;
			return 1'b1;
		end
		if (st.alarm_on && (now - st.last_send_ms) >= resend_ms) begin
			st.last_send_ms = now;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic result_t grade_and_debounce(vitals_t v);
		result_t r;
		logic hr_cond;
		logic sat_cond;
		if (v.pulse_rate_nan || v.oxygen_sat_nan || v.pulse_rate == 0 || v.oxygen_sat == 0)
			return REJECTED;
		r.sample_valid = 1'b1;
		r.hr_grade = grade_heart(v.pulse_rate, v.activity);
		r.spo2_grade = grade_oxygen(v.oxygen_sat);
		hr_cond = r.hr_grade != GRADE_NORMAL && r.hr_grade != GRADE_INVALID;
		sat_cond = r.spo2_grade == GRADE_VERY_LOW || r.spo2_grade == GRADE_LOW;
		r.hr_alert_send = advance_alarm(hr_track, hr_cond, v.now_ms);
		r.spo2_alert_send = advance_alarm(sat_track, sat_cond, v.now_ms);
		return r;
	endfunction

	function automatic void store_reg(reg_idx_t idx, logic [31:0] data);
		case (idx)
			REG_HR_VERY_LOW_MAX:    hr_thr[0] = data[7:0];
			REG_HR_LOW_MAX:         hr_thr[1] = data[7:0];
			REG_HR_NORMAL_MAX:      hr_thr[2] = data[7:0];
			REG_HR_HIGH_MAX:        hr_thr[3] = data[7:0];
			REG_SAT_VERY_LOW_MAX:   sat_thr[0] = data[6:0];
			REG_SAT_LOW_MAX:        sat_thr[1] = data[6:0];
			REG_SAT_NORMAL_MAX:     sat_thr[2] = data[6:0];
			REG_RESEND_INTERVAL_MS: resend_ms = data;
			default: ;
		endcase
	endfunction

	function automatic logic [11:0] near_heart();
		int v;
		v = int'({hr_thr[$urandom_range(0, 3)], 4'h0}) + int'($urandom_range(0, 4)) - 2;
		return (v < 0) ? 12'd0 : (v > 4095) ? 12'd4095 : 12'(v);
	endfunction

	function automatic logic [10:0] near_oxygen();
		int v;
		v = int'({sat_thr[$urandom_range(0, 2)], 4'h0}) + int'($urandom_range(0, 4)) - 2;
		return (v < 0) ? 11'd0 : (v > 2047) ? 11'd2047 : 11'(v);
	endfunction

	// advance the sample clock, often by about one resend interval
	function automatic logic [31:0] next_time();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			clock_ms = clock_ms + $urandom_range(0, 40);
		else if (roll < 85)
			clock_ms = clock_ms + resend_ms + $urandom_range(0, 2) - 32'd1;
		else if (roll < 95)
			clock_ms = clock_ms + (resend_ms >> 1);
		else
			clock_ms = $urandom;
		return clock_ms;
	endfunction

	task automatic send_vitals(input vitals_t v, input logic typed, input result_t want);
		result_t predicted;
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, v.now_ms, v.activity, v.oxygen_sat, v.pulse_rate};
		s_tuser <= {v.oxygen_sat_nan, v.pulse_rate_nan};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = grade_and_debounce(v);
		awaited_results.push_back(typed ? want : predicted);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		store_reg(idx, data);
	endtask

	task automatic apply_setting(input logic [31:0] hvl, hl, hn, hh, svl, sl, sn, resend);
		write_reg(REG_HR_VERY_LOW_MAX, hvl);
		write_reg(REG_HR_LOW_MAX, hl);
		write_reg(REG_HR_NORMAL_MAX, hn);
		write_reg(REG_HR_HIGH_MAX, hh);
		write_reg(REG_SAT_VERY_LOW_MAX, svl);
		write_reg(REG_SAT_LOW_MAX, sl);
		write_reg(REG_SAT_NORMAL_MAX, sn);
		write_reg(REG_RESEND_INTERVAL_MS, resend);
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{sample_valid: m_tuser, hr_grade: grade_t'(m_tdata[2:0]),
				spo2_grade: grade_t'(m_tdata[5:3]), hr_alert_send: m_tdata[6],
				spo2_alert_send: m_tdata[7]};
			if (awaited_results.size() == 0) begin
				$error("result with no sample outstanding: tdata %h tuser %b", m_tdata, m_tuser);
				mismatches++;
			end else begin
				want = awaited_results.pop_front();
				if (got.sample_valid !== want.sample_valid) begin
					$error("sample_valid: expected %0d, got %0d", want.sample_valid,
						got.sample_valid);
					mismatches++;
				end
				if (got.hr_grade !== want.hr_grade) begin
					$error("hr_grade: expected %0d, got %0d", want.hr_grade, got.hr_grade);
					mismatches++;
				end
				if (got.spo2_grade !== want.spo2_grade) begin
					$error("spo2_grade: expected %0d, got %0d", want.spo2_grade,
						got.spo2_grade);
					mismatches++;
				end
				if (got.hr_alert_send !== want.hr_alert_send) begin
					$error("hr_alert_send: expected %0d, got %0d", want.hr_alert_send,
						got.hr_alert_send);
					mismatches++;
				end
				if (got.spo2_alert_send !== want.spo2_alert_send) begin
					$error("spo2_alert_send: expected %0d, got %0d", want.spo2_alert_send,
						got.spo2_alert_send);
					mismatches++;
				end
			end
		end
	end

	initial begin
		vitals_t base;
		vitals_t item;
		int phase_items;
		int run_len;
		int unsigned roll;

		hr_thr[0] = HR_VERY_LOW_RESET;
		hr_thr[1] = HR_LOW_RESET;
		hr_thr[2] = HR_NORMAL_RESET;
		hr_thr[3] = HR_HIGH_RESET;
		sat_thr[0] = SPO2_VERY_LOW_RESET;
		sat_thr[1] = SPO2_LOW_RESET;
		sat_thr[2] = SPO2_NORMAL_RESET;
		resend_ms = RESEND_INTERVAL_RESET;
		hr_track = '0;
		sat_track = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_vitals(directed_rows[i].smp, directed_rows[i].typed, directed_rows[i].want);
		settle();

		for (int phase = 1; phase <= 6; phase++) begin
			case (phase)
				1: apply_setting(0, 0, 0, 0, 0, 0, 0, 0);
				2: apply_setting(32'hFF, 32'hFF, 32'hFF, 32'hFF, 32'h7F, 32'h7F, 32'h7F,
					32'hFFFF_FFFF);
				// reset values with junk above each register's width
				3: apply_setting(($urandom << 8) | HR_VERY_LOW_RESET,
					($urandom << 8) | HR_LOW_RESET, ($urandom << 8) | HR_NORMAL_RESET,
					($urandom << 8) | HR_HIGH_RESET, ($urandom << 7) | SPO2_VERY_LOW_RESET,
					($urandom << 7) | SPO2_LOW_RESET, ($urandom << 7) | SPO2_NORMAL_RESET,
					RESEND_INTERVAL_RESET);
				6: apply_setting($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom);
				default: apply_setting($urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom_range(0, 200));
			endcase
			quiet = (phase == 3);
			phase_items = 0;

			// hold both conditions long enough to saturate the hold counters
			if (phase == 3) begin
				base = '{12'd4000, 1'b0, 11'd1, 1'b0, ACT_RESTING, 32'd0};
				repeat (270) begin
					base.now_ms = next_time();
					send_vitals(base, 1'b0, REJECTED);
					phase_items++;
				end
				quiet = 1'b0;
			end

			while (phase_items < PHASE_ITEMS) begin
				run_len = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 12)
					: $urandom_range(13, 40);
				base.pulse_rate = $urandom_range(0, 1) ? near_heart()
					: 12'($urandom_range(1, 4095));
				base.oxygen_sat = $urandom_range(0, 1) ? near_oxygen()
					: 11'($urandom_range(1, 2047));
				base.pulse_rate_nan = 1'b0;
				base.oxygen_sat_nan = 1'b0;
				base.activity = ($urandom_range(0, 99) < 85) ? 2'($urandom_range(0, 1))
					: 2'($urandom_range(2, 3));
				repeat (run_len) begin
					item = base;
					roll = $urandom_range(0, 99);
					if (roll < 8) begin
						item.pulse_rate = base.pulse_rate + 12'($urandom_range(0, 2)) - 12'd1;
						item.oxygen_sat = base.oxygen_sat + 11'($urandom_range(0, 2)) - 11'd1;
					end else if (roll < 14) begin
						item.pulse_rate = 12'($urandom);
						item.oxygen_sat = 11'($urandom);
						item.pulse_rate_nan = ($urandom_range(0, 99) < 25);
						item.oxygen_sat_nan = ($urandom_range(0, 99) < 25);
						item.activity = 2'($urandom_range(0, 3));
					end
					item.now_ms = next_time();
					send_vitals(item, 1'b0, REJECTED);
					phase_items++;
				end
			end
			settle();
		end

		if (mismatches == 0 && awaited_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
